### rtl/dbga_pkg.sv
// shared types and codes for the detection box grid assigner
package dbga_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAIN_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_MODE = 3'd5;

  // result status codes
  localparam logic [2:0] ST_PLACED    = 3'd0;
  localparam logic [2:0] ST_BAD_CLASS = 3'd1;
  localparam logic [2:0] ST_OUTSIDE   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;

  // one in q1.16
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef struct packed {
    logic        func;
    logic [7:0]  obj_class;
    logic [16:0] center_x;
    logic [16:0] center_y;
    logic [17:0] box_w;
    logic [17:0] box_h;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  cell_row;
    logic [2:0]  cell_col;
    logic        slot;
    logic [18:0] x_value;
    logic [18:0] y_value;
    logic [16:0] w_value;
    logic [16:0] h_value;
    logic [7:0]  class_out;
  } result_t;

  typedef struct packed {
    logic               train_mode;
    logic [17:0]        inv_scale;
    logic signed [17:0] shift_x;
    logic signed [17:0] shift_y;
    logic [5:0]         class_count;
    logic               layout_mode;
  } cfg_t;

  // coordinate mapping results handed back to the sequencer
  typedef struct packed {
    logic        done;
    logic        bad_x;
    logic        bad_y;
    logic [16:0] x;
    logic [16:0] y;
    logic [16:0] w;
    logic [16:0] h;
  } map_res_t;

endpackage

### rtl/dbga_map_unit.sv
// augmentation undo and size clamp over one shared multiplier, one coordinate per step
module dbga_map_unit import dbga_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  item_t    item,
  input  cfg_t     cfg,
  output map_res_t res
);

  localparam logic [2:0] LAST_STEP = 3'd4;

  logic              busy;
  logic [2:0]        cnt;
  logic signed [19:0] tx;
  logic signed [19:0] ty;
  logic signed [19:0] op;
  logic signed [38:0] prod;
  logic [16:0]       c_orig;
  logic signed [39:0] n;
  logic signed [39:0] nr;
  logic              c_bad;
  logic [16:0]       c_val;
  logic [17:0]       s_orig;
  logic signed [38:0] sr;
  logic [21:0]       s_raw;
  logic [16:0]       s_val;
  logic              bad_x;
  logic              bad_y;
  logic [16:0]       x_q;
  logic [16:0]       y_q;
  logic [16:0]       w_q;
  logic [16:0]       h_q;

  // centered and shifted coordinates: 2c - 1 - shift
  assign tx = $signed({2'b00, item.center_x, 1'b0}) - 20'sh10000 - 20'($signed(cfg.shift_x));
  assign ty = $signed({2'b00, item.center_y, 1'b0}) - 20'sh10000 - 20'($signed(cfg.shift_y));

  // operand for the current step
  always_comb begin
    case (cnt[1:0])
      2'd0:    op = tx;
      2'd1:    op = ty;
      2'd2:    op = $signed({2'b00, item.box_w});
      default: op = $signed({2'b00, item.box_h});
    endcase
  end

  // center post-processing: range check and round to nearest
  always_comb begin
    c_orig = (cnt == 3'd1) ? item.center_x : item.center_y;
    n      = 40'(prod) + 40'sh1_0000_0000;
    nr     = n + 40'sh1_0000;
    if (cfg.train_mode) begin
      c_bad = n[39] || (n > 40'sh2_0000_0000);
      c_val = nr[33:17];
    end else begin
      c_bad = c_orig > ONE_Q16;
      c_val = c_orig;
    end
  end

  // size post-processing: round and clamp to one
  always_comb begin
    s_orig = (cnt == 3'd3) ? item.box_w : item.box_h;
    sr     = prod + 39'sh8000;
    s_raw  = cfg.train_mode ? 22'(sr[37:16]) : {4'b0000, s_orig};
    s_val  = (s_raw > 22'd65536) ? ONE_Q16 : s_raw[16:0];
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 3'd1;
      if (cnt == LAST_STEP) begin
        busy <= 1'b0;
      end
    end
  end

  // multiply then post-process the previous step's product
  always_ff @(posedge clk) begin
    if (busy) begin
      if (cnt != LAST_STEP) begin
        prod <= op * $signed({1'b0, cfg.inv_scale});
      end
      case (cnt)
        3'd1: begin
          bad_x <= c_bad;
          x_q   <= c_val;
        end
        3'd2: begin
          bad_y <= c_bad;
          y_q   <= c_val;
        end
        3'd3:    w_q <= s_val;
        3'd4:    h_q <= s_val;
        default: ;
      endcase
    end
  end

  assign res.done  = busy && (cnt == LAST_STEP);
  assign res.bad_x = bad_x;
  assign res.bad_y = bad_y;
  assign res.x     = x_q;
  assign res.y     = y_q;
  assign res.w     = w_q;
  assign res.h     = h_q;

endmodule

### rtl/detection_box_grid_assigner.sv
// top level: yolo style grid cell assignment with occupancy memory
//
// Usage: one labelled box or one clear command is taken per item beat on
// item_valid/item_ready; each item gives exactly one result beat on
// result_valid/result_ready. Registers are written on cfg_valid/cfg_ready
// (always ready) with cfg_index selecting the register; write them only while
// the block is idle.
// A place item runs from accept to the next accept through five steps of the
// shared coordinate multiplier, grid scaling, occupancy read, occupancy
// write, then the result register. A rejected box skips the occupancy write.
// A clear item sweeps all GRID_CELLS*GRID_CELLS cells of the occupancy
// memory (49 by default), one cell per cycle, and then gives its result.
// After reset the same sweep runs once before the first item is taken;
// configuration returns to its reset values at once.
// The result sits in an output register; while the receiver stalls the next
// item is still taken and worked on, and it waits before the output register
// until that register is free.
module detection_box_grid_assigner import dbga_pkg::*; #(
  parameter int GRID_CELLS     = 7,
  parameter int SLOTS_PER_CELL = 2,
  parameter int MAX_CLASSES    = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = GRID_CELLS * GRID_CELLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(GRID_CELLS);
  localparam int SW     = 17 + COL_W;
  localparam int CR_W   = SW - 16;
  localparam int SLOT_W = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(DEPTH - 1);
  localparam logic [CR_W-1:0]   COL_MAX     = CR_W'(GRID_CELLS - 1);
  localparam logic [8:0]        CLASS_LIMIT = 9'(MAX_CLASSES);

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MAP   = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                state;
  logic [ADDR_W-1:0]         sweep_cnt;
  logic                      clr_pend;
  cfg_t                      cfg;
  item_t                     item_q;
  result_t                   res_q;
  map_res_t                  map_res;
  logic                      map_start;
  logic                      accept;

  logic [SW-1:0]             sx_next;
  logic [SW-1:0]             sy_next;
  logic [CR_W-1:0]           col_raw;
  logic [CR_W-1:0]           row_raw;
  logic [COL_W-1:0]          col_next;
  logic [COL_W-1:0]          row_next;
  logic [8:0]                class_lim;
  logic                      class_bad_next;

  logic [SW-1:0]             sx;
  logic [SW-1:0]             sy;
  logic [COL_W-1:0]          col;
  logic [COL_W-1:0]          row;
  logic                      class_bad;
  logic [ADDR_W-1:0]         addr_calc;
  logic [ADDR_W-1:0]         addr;
  logic                      reject;

  logic [SLOTS_PER_CELL-1:0] occ_mem [DEPTH];
  logic [SLOTS_PER_CELL-1:0] rd_occ;
  logic [SLOTS_PER_CELL-1:0] occ_new;
  logic                      placed;
  logic [SLOT_W-1:0]         slot_k;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic [SLOTS_PER_CELL-1:0] mem_wdata;

  result_t                   res_clear;
  result_t                   res_reject;
  result_t                   res_write;

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && item_ready;
  assign map_start  = accept && !item.func;

  dbga_map_unit u_map (
    .clk   (clk),
    .rst   (rst),
    .start (map_start),
    .item  (item_q),
    .cfg   (cfg),
    .res   (map_res)
  );

  // grid scaling and cell pick
  always_comb begin
    sx_next  = SW'(map_res.x) * SW'(GRID_CELLS);
    sy_next  = SW'(map_res.y) * SW'(GRID_CELLS);
    col_raw  = sx_next[SW-1:16];
    row_raw  = sy_next[SW-1:16];
    col_next = (col_raw > COL_MAX) ? COL_W'(GRID_CELLS - 1) : col_raw[COL_W-1:0];
    row_next = (row_raw > COL_MAX) ? COL_W'(GRID_CELLS - 1) : row_raw[COL_W-1:0];
  end

  // class range check against the smaller of register and ceiling
  always_comb begin
    class_lim      = (9'(cfg.class_count) > CLASS_LIMIT) ? CLASS_LIMIT : 9'(cfg.class_count);
    class_bad_next = {1'b0, item_q.obj_class} >= class_lim;
  end

  assign addr_calc = ADDR_W'(row) * ADDR_W'(GRID_CELLS) + ADDR_W'(col);
  assign reject    = class_bad || map_res.bad_x || map_res.bad_y;

  // free slot search on the read-back occupancy
  always_comb begin
    placed  = 1'b0;
    slot_k  = '0;
    occ_new = rd_occ;
    if (!cfg.layout_mode) begin
      if (!rd_occ[0]) begin
        placed     = 1'b1;
        occ_new[0] = 1'b1;
      end
    end else begin
      for (int k = 0; k < SLOTS_PER_CELL; k++) begin
        if (!placed && !rd_occ[k]) begin
          placed     = 1'b1;
          occ_new[k] = 1'b1;
          slot_k     = SLOT_W'(k);
        end
      end
    end
  end

  // result candidates
  always_comb begin
    res_clear        = '0;
    res_clear.status = ST_CLEARED;

    res_reject           = '0;
    res_reject.status    = class_bad ? ST_BAD_CLASS : ST_OUTSIDE;
    res_reject.class_out = item_q.obj_class;

    res_write           = '0;
    res_write.status    = placed ? ST_PLACED : ST_FULL;
    res_write.cell_row  = 3'(row);
    res_write.cell_col  = 3'(col);
    res_write.slot      = placed ? slot_k[0] : 1'b0;
    res_write.w_value   = map_res.w;
    res_write.h_value   = map_res.h;
    res_write.class_out = item_q.obj_class;
    if (!cfg.layout_mode) begin
      res_write.x_value = 19'(sx);
      res_write.y_value = 19'(sy);
    end else begin
      res_write.x_value = 19'(sx - SW'({col, 16'h0000}));
      res_write.y_value = 19'(sy - SW'({row, 16'h0000}));
    end
  end

  // occupancy write port: sweep clears, place sets a bit
  always_comb begin
    mem_we    = (state == S_SWEEP) || ((state == S_WRITE) && placed);
    mem_waddr = (state == S_SWEEP) ? sweep_cnt : addr;
    mem_wdata = (state == S_SWEEP) ? '0 : occ_new;
  end

  // occupancy memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[mem_waddr] <= mem_wdata;
    end
    rd_occ <= occ_mem[addr_calc];
  end

  // control, configuration and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_SWEEP;
      sweep_cnt        <= '0;
      clr_pend         <= 1'b0;
      result_valid     <= 1'b0;
      cfg.train_mode   <= 1'b0;
      cfg.inv_scale    <= 18'd65536;
      cfg.shift_x      <= '0;
      cfg.shift_y      <= '0;
      cfg.class_count  <= 6'd20;
      cfg.layout_mode  <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TRAIN_MODE:  cfg.train_mode  <= cfg_data[0];
          CFG_INV_SCALE:   cfg.inv_scale   <= cfg_data;
          CFG_SHIFT_X:     cfg.shift_x     <= $signed(cfg_data);
          CFG_SHIFT_Y:     cfg.shift_y     <= $signed(cfg_data);
          CFG_CLASS_COUNT: cfg.class_count <= cfg_data[5:0];
          CFG_LAYOUT_MODE: cfg.layout_mode <= cfg_data[0];
          default: ;
        endcase
      end
      // output valid: load a finished result or drop an accepted one
      if ((state == S_DONE) && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_SWEEP: begin
          if (sweep_cnt == LAST_ADDR) begin
            sweep_cnt <= '0;
            clr_pend  <= 1'b0;
            state     <= clr_pend ? S_DONE : S_IDLE;
          end else begin
            sweep_cnt <= sweep_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (item.func) begin
              clr_pend <= 1'b1;
              state    <= S_SWEEP;
            end else begin
              state <= S_MAP;
            end
          end
        end
        S_MAP: begin
          if (map_res.done) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: state <= S_READ;
        S_READ:  state <= reject ? S_DONE : S_WRITE;
        S_WRITE: state <= S_DONE;
        S_DONE: begin
          if (!result_valid || result_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
      res_q  <= res_clear;
    end
    if (state == S_SCALE) begin
      sx        <= sx_next;
      sy        <= sy_next;
      col       <= col_next;
      row       <= row_next;
      class_bad <= class_bad_next;
    end
    if (state == S_READ) begin
      addr <= addr_calc;
      if (reject) begin
        res_q <= res_reject;
      end
    end
    if (state == S_WRITE) begin
      res_q <= res_write;
    end
    if ((state == S_DONE) && (!result_valid || result_ready)) begin
      result <= res_q;
    end
  end

  // occupancy is only written by the sweep or a place
  a_mem_we_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_SWEEP || state == S_WRITE))
    else $error("occupancy written outside sweep or write");

  // the mapping unit finishes only while the sequencer waits for it
  a_map_done_state: assert property (@(posedge clk) disable iff (rst)
    map_res.done |-> (state == S_MAP))
    else $error("map unit done outside map state");

  // a finished result is held back, not dropped, while the output is full
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && result_valid && !result_ready) |=> (state == S_DONE))
    else $error("pending result left while output register full");

  // after the read the item either writes or reports a rejection
  a_read_next: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_WRITE || state == S_DONE))
    else $error("bad state after occupancy read");

endmodule
